FILE: design/assert_macros.svh
// shared assertion macros for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true at an edge implies cons at the same edge
`define AST_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante true at an edge implies cons at the next edge
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rtds_pkg.sv
package rtds_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned LevelWidth    = 16;
   localparam int unsigned TimeWidth     = 32;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_BRAKE_THRESHOLD    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_THROTTLE_THRESHOLD = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HV_OVERRIDE_MS     = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BUZZER_MS          = 2'd3;

   // register values after reset
   localparam logic [LevelWidth-1:0] BRAKE_THRESHOLD_RESET    = 16'd200;
   localparam logic [LevelWidth-1:0] THROTTLE_THRESHOLD_RESET = 16'd0;
   localparam logic [LevelWidth-1:0] HV_OVERRIDE_MS_RESET     = 16'd1000;
   localparam logic [LevelWidth-1:0] BUZZER_MS_RESET          = 16'd2000;

   typedef struct packed {
      logic [TimeWidth-1:0]  time_ms;
      logic                  drive_button;
      logic [LevelWidth-1:0] brake_level;
      logic [LevelWidth-1:0] throttle_level;
      logic                  hv_good;
      logic                  halt_request;
   } req_type;

   typedef struct packed {
      logic [1:0] car_state;
      logic       brake_lamp;
      logic       buzzer_on;
      logic       drive_enable;
      logic       bms_poll_active;
   } rsp_type;

endpackage

FILE: design/ready_to_drive_sequencer_core.sv
// Ready-to-drive start sequencer.
// req channel: one word per control tick (timestamp, drive button, brake and
//   throttle levels, hv ready, force stop), taken when req_valid is high and
//   req_stall is low.
// rsp channel: one word per tick with the state after the tick and the brake
//   light, buzzer, drive enable and bms polling outputs; taken when rsp_valid
//   is high and rsp_stall is low.
// csr channel: csr_index selects brake threshold, throttle threshold, hv
//   override time or buzzer time; csr_ready is always high. Write only while
//   no tick is in flight.
// An accepted tick's rsp word lands in the result or skid register. One tick
// can be taken every cycle while req_stall is low: the state update is a single
// compare-and-subtract pass on the input word into state and result registers.
// A two-deep output (result register plus skid register) absorbs a stall:
// req_stall rises only once both hold words, and nothing is lost.
// Synchronous reset puts the sequence in init with entry time zero, loads the
// default register values and empties the output.
`include "assert_macros.svh"

module ready_to_drive_sequencer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rtds_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rtds_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rtds_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rtds_pkg::LevelWidth-1:0]       csr_data
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_STARTING,
      ST_BUZZING,
      ST_DRIVE
   } state_type;

   state_type                           seq_state_ff, seq_state_in;
   logic [rtds_pkg::TimeWidth-1:0]      entry_time_ff, entry_time_in;
   logic [rtds_pkg::LevelWidth-1:0]     brake_thr_ff, throttle_thr_ff;
   logic [rtds_pkg::LevelWidth-1:0]     hv_override_ff, buzzer_ms_ff;

   rtds_pkg::rsp_type                   rsp_ff, rsp_in;
   rtds_pkg::rsp_type                   skid_ff, skid_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                skid_valid_ff, skid_valid_in;

   rtds_pkg::rsp_type                   result;
   logic                                req_accept;
   logic                                rsp_take;
   logic                                brake_down;
   logic                                check_throttle;
   logic [rtds_pkg::TimeWidth-1:0]      elapsed;
   logic                                csr_write;
   logic                                halt_take;
   logic                                drive_stay;
   logic                                rsp_flags_ok;

   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign csr_write  = csr_valid && csr_ready;

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign brake_down = req_data.brake_level >= brake_thr_ff;
   // wrapping difference, so a timestamp rollover still measures correctly
   assign elapsed = req_data.time_ms - entry_time_ff;

   always_comb begin
      seq_state_in   = seq_state_ff;
      entry_time_in  = entry_time_ff;
      check_throttle = 1'b1;
      if (req_data.halt_request) begin
         seq_state_in   = ST_INIT;
         check_throttle = 1'b0;
      end else begin
         case (seq_state_ff)
            ST_DRIVE: begin
               check_throttle = 1'b0;
            end
            ST_INIT: begin
               if (req_data.drive_button && brake_down) begin
                  seq_state_in  = ST_STARTING;
                  entry_time_in = req_data.time_ms;
               end
            end
            ST_STARTING: begin
               if (!req_data.drive_button || !brake_down) begin
                  seq_state_in  = ST_INIT;
                  entry_time_in = req_data.time_ms;
               end else if (req_data.hv_good ||
                            elapsed >= {16'd0, hv_override_ff}) begin
                  seq_state_in  = ST_BUZZING;
                  entry_time_in = req_data.time_ms;
               end
            end
            ST_BUZZING: begin
               if (elapsed >= {16'd0, buzzer_ms_ff}) begin
                  seq_state_in = ST_DRIVE;
               end
            end
            default: begin
               seq_state_in = ST_INIT;
            end
         endcase
      end
      // throttle abort overrides any transition taken this tick, but is skipped on a halt request and in drive
      if (check_throttle && req_data.throttle_level > throttle_thr_ff) begin
         seq_state_in  = ST_INIT;
         entry_time_in = req_data.time_ms;
      end
   end

   always_comb begin
      result.car_state       = seq_state_in;
      result.brake_lamp      = brake_down;
      result.buzzer_on       = seq_state_in == ST_BUZZING;
      result.drive_enable    = seq_state_in == ST_DRIVE;
      result.bms_poll_active = seq_state_in == ST_STARTING;
   end

   // result register plus skid register
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_take || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff    <= ST_INIT;
         entry_time_ff   <= '0;
         brake_thr_ff    <= rtds_pkg::BRAKE_THRESHOLD_RESET;
         throttle_thr_ff <= rtds_pkg::THROTTLE_THRESHOLD_RESET;
         hv_override_ff  <= rtds_pkg::HV_OVERRIDE_MS_RESET;
         buzzer_ms_ff    <= rtds_pkg::BUZZER_MS_RESET;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            seq_state_ff  <= seq_state_in;
            entry_time_ff <= entry_time_in;
         end
         if (csr_write) begin
            case (csr_index)
               rtds_pkg::CSR_BRAKE_THRESHOLD:    brake_thr_ff    <= csr_data;
               rtds_pkg::CSR_THROTTLE_THRESHOLD: throttle_thr_ff <= csr_data;
               rtds_pkg::CSR_HV_OVERRIDE_MS:     hv_override_ff  <= csr_data;
               rtds_pkg::CSR_BUZZER_MS:          buzzer_ms_ff    <= csr_data;
               default: begin
               end
            endcase
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign halt_take    = req_accept && req_data.halt_request;
   assign drive_stay   = seq_state_ff == ST_DRIVE && !halt_take;
   assign rsp_flags_ok = rsp_ff.drive_enable == (rsp_ff.car_state == ST_DRIVE) &&
                         rsp_ff.buzzer_on == (rsp_ff.car_state == ST_BUZZING);

   `AST_IMPLY(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff, "orphan skid word")
   `AST_NEXT(a_halt_init, clock, reset, halt_take, seq_state_ff == ST_INIT, "halt missed init")
   `AST_NEXT(a_drive_holds, clock, reset, drive_stay, seq_state_ff == ST_DRIVE, "drive left")
   `AST_IMPLY(a_rsp_flags, clock, reset, rsp_valid_ff, rsp_flags_ok, "bad output flags")

endmodule

FILE: sim/ready_to_drive_sequencer_core_test.sv
module ready_to_drive_sequencer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 200000;

   typedef enum logic [1:0] {
      SEQ_INIT     = 2'd0,
      SEQ_STARTING = 2'd1,
      SEQ_BUZZING  = 2'd2,
      SEQ_DRIVE    = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic [rtds_pkg::CsrIndexWidth-1:0] idx;
      logic [rtds_pkg::LevelWidth-1:0]    value;
   } csr_write_type;

   logic clock;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   rtds_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   rtds_pkg::rsp_type                  rsp_data;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [rtds_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [rtds_pkg::LevelWidth-1:0]    csr_data = '0;

   // predictor copy of the registers and the sequence
   logic [rtds_pkg::LevelWidth-1:0] brake_limit    = rtds_pkg::BRAKE_THRESHOLD_RESET;
   logic [rtds_pkg::LevelWidth-1:0] throttle_limit = rtds_pkg::THROTTLE_THRESHOLD_RESET;
   logic [rtds_pkg::LevelWidth-1:0] hv_wait_ms     = rtds_pkg::HV_OVERRIDE_MS_RESET;
   logic [rtds_pkg::LevelWidth-1:0] buzz_ms        = rtds_pkg::BUZZER_MS_RESET;
   seq_state_type                   seq_state      = SEQ_INIT;
   logic [rtds_pkg::TimeWidth-1:0]  entry_ms       = '0;

   rtds_pkg::req_type pending_ticks[$];
   rtds_pkg::rsp_type expected_words[$];
   csr_write_type     csr_writes[$];

   logic [rtds_pkg::TimeWidth-1:0] now_ms = '0;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  req_gap = 0;
   bit  req_steady = 1'b0;
   int  rsp_hold = 0;
   bit  rsp_steady = 1'b0;

   ready_to_drive_sequencer_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic predict_tick(input rtds_pkg::req_type w);
      logic                           pressed;
      logic [rtds_pkg::TimeWidth-1:0] elapsed;
      logic                           throttle_check;
      rtds_pkg::rsp_type              r;
      pressed = w.brake_level >= brake_limit;
      elapsed = w.time_ms - entry_ms;
      throttle_check = 1'b1;
      if (w.halt_request) begin
         // entry time is left alone on a forced stop
         seq_state = SEQ_INIT;
         throttle_check = 1'b0;
      end else begin
         case (seq_state)
            SEQ_DRIVE: begin
               throttle_check = 1'b0;
            end
            SEQ_INIT: begin
               if (w.drive_button && pressed) begin
                  seq_state = SEQ_STARTING;
                  entry_ms = w.time_ms;
               end
            end
            SEQ_STARTING: begin
               if (!w.drive_button || !pressed) begin
                  seq_state = SEQ_INIT;
                  entry_ms = w.time_ms;
               end else if (w.hv_good || elapsed >= {16'd0, hv_wait_ms}) begin
                  seq_state = SEQ_BUZZING;
                  entry_ms = w.time_ms;
               end
            end
            default: begin
               if (elapsed >= {16'd0, buzz_ms}) seq_state = SEQ_DRIVE;
            end
         endcase
      end
      // abort also catches a tick that just moved into drive
      if (throttle_check && w.throttle_level > throttle_limit) begin
         seq_state = SEQ_INIT;
         entry_ms = w.time_ms;
      end
      r.car_state       = seq_state;
      r.brake_lamp      = pressed;
      r.buzzer_on       = seq_state == SEQ_BUZZING;
      r.drive_enable    = seq_state == SEQ_DRIVE;
      r.bms_poll_active = seq_state == SEQ_STARTING;
      expected_words.push_back(r);
   endtask

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) predict_tick(req_data);
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_ticks.size() != 0) begin
            req_data <= pending_ticks.pop_front();
            req_valid <= 1'b1;
            req_gap <= req_steady ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 39) == 0) req_steady <= !req_steady;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               rtds_pkg::rsp_type want;
               want = expected_words.pop_front();
               check_field("car_state", 32'(want.car_state),
                           32'(rsp_data.car_state));
               check_field("brake_lamp", 32'(want.brake_lamp),
                           32'(rsp_data.brake_lamp));
               check_field("buzzer_on", 32'(want.buzzer_on),
                           32'(rsp_data.buzzer_on));
               check_field("drive_enable", 32'(want.drive_enable),
                           32'(rsp_data.drive_enable));
               check_field("bms_poll_active", 32'(want.bms_poll_active),
                           32'(rsp_data.bms_poll_active));
            end
            rsp_hold = rsp_steady ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         end else if (rsp_hold != 0) begin
            rsp_hold--;
         end
         rsp_stall <= rsp_hold != 0;
      end
   end

   // register write channel
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rtds_pkg::CSR_BRAKE_THRESHOLD:    brake_limit = csr_data;
               rtds_pkg::CSR_THROTTLE_THRESHOLD: throttle_limit = csr_data;
               rtds_pkg::CSR_HV_OVERRIDE_MS:     hv_wait_ms = csr_data;
               rtds_pkg::CSR_BUZZER_MS:          buzz_ms = csr_data;
               default: ;
            endcase
         end
         if (csr_valid && !csr_ready) begin
            // hold until taken
         end else if (csr_writes.size() != 0) begin
            csr_write_type w;
            w = csr_writes.pop_front();
            csr_valid <= 1'b1;
            csr_index <= w.idx;
            csr_data <= w.value;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_ticks.size() != 0 || expected_words.size() != 0 ||
             csr_writes.size() != 0 || req_valid || csr_valid)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic queue_tick(input logic [rtds_pkg::TimeWidth-1:0] t, input logic button,
                             input logic [rtds_pkg::LevelWidth-1:0] brake,
                             input logic [rtds_pkg::LevelWidth-1:0] throttle,
                             input logic hv, input logic stop);
      rtds_pkg::req_type w;
      w.time_ms        = t;
      w.drive_button   = button;
      w.brake_level    = brake;
      w.throttle_level = throttle;
      w.hv_good        = hv;
      w.halt_request   = stop;
      pending_ticks.push_back(w);
   endtask

   task automatic queue_random_tick(input int step_max);
      rtds_pkg::req_type w;
      bit                tidy;
      tidy = $urandom_range(0, 4) != 0;
      if ($urandom_range(0, 49) == 0) now_ms = $urandom;
      else now_ms += $urandom_range(0, step_max);
      w.time_ms = now_ms;
      if (tidy) begin
         // a start attempt that mostly gets through to drive
         w.drive_button = $urandom_range(0, 29) != 0;
         w.brake_level = 16'($urandom_range(16'hFFFF, brake_limit));
         if ($urandom_range(0, 29) == 0) begin
            w.throttle_level = 16'($urandom_range(0, 16'hFFFF));
         end else begin
            w.throttle_level = 16'($urandom_range(throttle_limit, 0));
         end
         w.hv_good = $urandom_range(0, 7) == 0;
         w.halt_request = $urandom_range(0, 59) == 0;
      end else begin
         w.drive_button = 1'($urandom_range(0, 1));
         w.brake_level = 16'($urandom_range(0, 16'hFFFF));
         w.throttle_level = 16'($urandom_range(0, 16'hFFFF));
         w.hv_good = 1'($urandom_range(0, 1));
         w.halt_request = $urandom_range(0, 3) == 0;
      end
      pending_ticks.push_back(w);
   endtask

   task automatic run_phase(input logic [rtds_pkg::LevelWidth-1:0] brake,
                            input logic [rtds_pkg::LevelWidth-1:0] throttle,
                            input logic [rtds_pkg::LevelWidth-1:0] hv,
                            input logic [rtds_pkg::LevelWidth-1:0] buzz, input int count);
      int step_max;
      csr_writes.push_back('{idx: rtds_pkg::CSR_BRAKE_THRESHOLD, value: brake});
      csr_writes.push_back('{idx: rtds_pkg::CSR_THROTTLE_THRESHOLD, value: throttle});
      csr_writes.push_back('{idx: rtds_pkg::CSR_HV_OVERRIDE_MS, value: hv});
      csr_writes.push_back('{idx: rtds_pkg::CSR_BUZZER_MS, value: buzz});
      wait_idle();
      // time steps scaled so the timers fire within a handful of ticks
      step_max = ((hv > buzz) ? int'(hv) : int'(buzz)) / 3 + 2;
      repeat (count) queue_random_tick(step_max);
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed ticks on the reset register values
      queue_tick(32'd0, 1'b0, 16'd199, 16'd0, 1'b0, 1'b0);
      queue_tick(32'd10, 1'b1, 16'd199, 16'd0, 1'b0, 1'b0);    // brake just short
      queue_tick(32'd20, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);    // starting
      queue_tick(32'd500, 1'b1, 16'hFFFF, 16'd0, 1'b0, 1'b0);
      queue_tick(32'd1019, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);  // one ms short of override
      queue_tick(32'd1020, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);  // hv assumed, buzzing
      queue_tick(32'd3019, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
      queue_tick(32'd3020, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);    // drive
      queue_tick(32'd3021, 1'b0, 16'd0, 16'hFFFF, 1'b0, 1'b0); // throttle ignored in drive
      queue_tick(32'd3022, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1); // force stop
      queue_tick(32'd3030, 1'b1, 16'd200, 16'd1, 1'b0, 1'b0);  // start then throttle abort
      queue_tick(32'd3040, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);
      queue_tick(32'd3050, 1'b0, 16'd200, 16'd0, 1'b0, 1'b0);  // button released
      queue_tick(32'd3060, 1'b1, 16'd300, 16'd0, 1'b0, 1'b0);
      queue_tick(32'd3070, 1'b1, 16'd300, 16'd0, 1'b1, 1'b0);  // hv ready
      queue_tick(32'd3080, 1'b1, 16'd300, 16'd1, 1'b0, 1'b0);  // abort from buzzing
      // timestamp wrap across the starting timer
      queue_tick(32'hFFFF_FF00, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);
      queue_tick(32'h0000_02E7, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);
      queue_tick(32'h0000_02E8, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);
      queue_tick(32'h0000_0AB8, 1'b1, 16'd200, 16'd5, 1'b0, 1'b0); // into drive, then abort
      queue_tick(32'h0000_0B00, 1'b1, 16'd200, 16'd0, 1'b0, 1'b0);
      queue_tick(32'h0000_0B10, 1'b1, 16'd200, 16'd0, 1'b0, 1'b1); // stop while starting
      queue_tick(32'h0000_0B20, 1'b0, 16'd0, 16'd0, 1'b0, 1'b1);
      wait_idle();

      now_ms = $urandom;
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 160);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 160);
      run_phase(16'd1000, 16'd100, 16'd50, 16'd120, 220);
      run_phase(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)), 220);
      now_ms = 32'hFFFF_F000;
      run_phase(16'd200, 16'd0, 16'd1000, 16'd2000, 220);

      if (expected_words.size() != 0) begin
         $display("%0t: %0d words never arrived", $time, expected_words.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/rtds_pkg.sv
design/ready_to_drive_sequencer_core.sv
sim/ready_to_drive_sequencer_core_test.sv
